FILE: rtl/pdps_pkg.sv
package pdps_pkg;

    localparam int NUM_PROFILES    = 13;
    localparam int EXT_RANGE_FIRST = 7;
    localparam int PPS_STEP_MV     = 100;
    localparam int AVS_STEP_MV     = 200;

    localparam int IDX_W  = $clog2(NUM_PROFILES);
    localparam int STEP_W = 9;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROFILES - 1);

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_REQ  = 2'd1,
        CMD_PPS  = 2'd2,
        CMD_AVS  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FIXED = 2'd0,
        KIND_PPS   = 2'd1,
        KIND_AVS   = 2'd2
    } kind_t;

    typedef struct packed {
        logic             capture;
        logic             write;
        logic             sweep;
        logic [IDX_W-1:0] idx;
        logic             emit;
    } ctl_t;

    typedef struct packed {
        logic out_full;
    } sts_t;

    function automatic logic [12:0] amp_ma(input logic [3:0] code);
        logic [12:0] ma;
        unique case (code)
            4'd0:    ma = 13'd1000;
            4'd1:    ma = 13'd1250;
            4'd2:    ma = 13'd1500;
            4'd3:    ma = 13'd1750;
            4'd4:    ma = 13'd2000;
            4'd5:    ma = 13'd2250;
            4'd6:    ma = 13'd2500;
            4'd7:    ma = 13'd2750;
            4'd8:    ma = 13'd3000;
            4'd9:    ma = 13'd3250;
            4'd10:   ma = 13'd3500;
            4'd11:   ma = 13'd3750;
            4'd12:   ma = 13'd4000;
            4'd13:   ma = 13'd4250;
            4'd14:   ma = 13'd4500;
            default: ma = 13'd5000;
        endcase
        return ma;
    endfunction

    // highest code whose current does not exceed ma, 0 below the lowest step
    function automatic logic [3:0] encode_amps(input logic [15:0] ma);
        logic [3:0] code;
        code = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (ma >= {3'd0, amp_ma(4'(k))})
            begin
                code = 4'(k);
            end
        end
        return code;
    endfunction

endpackage

FILE: rtl/pdps_ctrl.sv
module pdps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     command,
    input  logic           out_stall,
    output logic           in_stall,
    output pdps_pkg::ctl_t ctl,
    input  pdps_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [pdps_pkg::IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        ctl.capture = 1'b0;
        ctl.write   = 1'b0;
        ctl.sweep   = 1'b0;
        ctl.idx     = idx_reg;
        ctl.emit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    idx_next    = '0;
                    if (command == pdps_pkg::CMD_LOAD)
                    begin
                        ctl.write  = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                ctl.sweep = 1'b1;
                if (idx_reg == pdps_pkg::LAST_IDX)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_full || !out_stall)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: rtl/pdps_datapath.sv
module pdps_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  pdps_pkg::ctl_t ctl,
    output pdps_pkg::sts_t sts,
    input  logic [1:0]     command,
    input  logic [3:0]     slot,
    input  logic [15:0]    profile_word,
    input  logic [15:0]    target_mv,
    input  logic [15:0]    current_ma,
    input  logic           out_stall,
    output logic           out_valid,
    output logic [3:0]     chosen_index,
    output logic [15:0]    request_word,
    output logic           is_adjustable_avs,
    output logic [3:0]     valid_count
);

    localparam logic [31:0] PPS_RECIP =
        32'((64'd1 << 32) / 64'(pdps_pkg::PPS_STEP_MV));
    localparam logic [31:0] AVS_RECIP =
        32'((64'd1 << 32) / 64'(pdps_pkg::AVS_STEP_MV));
    localparam logic [15:0] NORM_UNIT_MV = 16'd100;
    localparam logic [15:0] EXT_UNIT_MV  = 16'd200;
    localparam logic [15:0] PPS_BASE_MV  = 16'd3300;
    localparam logic [15:0] AVS_BASE_MV  = 16'd15000;

    localparam int IW = pdps_pkg::IDX_W;

    // profile table and valid count
    logic [15:0] table_reg [pdps_pkg::NUM_PROFILES];
    logic [3:0]  count_reg, count_next;
    logic        old_valid, slot_hit;

    always_comb
    begin
        old_valid = 1'b0;
        slot_hit  = 1'b0;
        for (int i = 0; i < pdps_pkg::NUM_PROFILES; i++)
        begin
            if (slot == 4'(i))
            begin
                old_valid = table_reg[i][15];
                slot_hit  = 1'b1;
            end
        end
        count_next = count_reg;
        if (ctl.write && slot_hit)
        begin
            count_next = count_reg - {3'd0, old_valid} + {3'd0, profile_word[15]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pdps_pkg::NUM_PROFILES; i++)
            begin
                table_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else
        begin
            if (ctl.write)
            begin
                for (int i = 0; i < pdps_pkg::NUM_PROFILES; i++)
                begin
                    if (slot == 4'(i))
                    begin
                        table_reg[i] <= profile_word;
                    end
                end
            end
            count_reg <= count_next;
        end
    end

    // request operands
    logic [1:0]                 cmd_reg;
    logic [15:0]                mv_reg, ma_reg;
    logic [pdps_pkg::STEP_W-1:0] step_reg;
    logic [31:0]                recip_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= command;
            mv_reg   <= target_mv;
            ma_reg   <= current_ma;
            if (command == pdps_pkg::CMD_AVS)
            begin
                step_reg  <= pdps_pkg::STEP_W'(pdps_pkg::AVS_STEP_MV);
                recip_reg <= AVS_RECIP;
            end
            else
            begin
                step_reg  <= pdps_pkg::STEP_W'(pdps_pkg::PPS_STEP_MV);
                recip_reg <= PPS_RECIP;
            end
        end
    end

    // voltage select: reciprocal multiply, then one correction step
    logic [47:0] prod_reg;
    logic [15:0] q_reg, q_est, q_next;
    logic [24:0] q_times_step, rem;

    always_comb
    begin
        q_est        = prod_reg[47:32];
        q_times_step = q_est * step_reg;
        rem          = {9'd0, mv_reg} - q_times_step;
        q_next       = (rem >= 25'(step_reg)) ? q_est + 16'd1 : q_est;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mv_reg * recip_reg;
        q_reg    <= q_next;
    end

    // decode of the swept entry
    logic [15:0]     ent;
    logic            ext, ent_valid;
    logic [3:0]      ent_code;
    pdps_pkg::kind_t ent_kind, want_kind;
    logic [15:0]     unit_mv, base_mv, min_mv, max_mv, diff;
    logic [23:0]     max_prod, min_prod;
    logic            range_hit, fixed_ok;

    always_comb
    begin
        ent       = table_reg[ctl.idx];
        ext       = (32'(ctl.idx) >= 32'(pdps_pkg::EXT_RANGE_FIRST));
        ent_valid = ent[15];
        ent_code  = ent[13:10];
        unit_mv   = ext ? EXT_UNIT_MV : NORM_UNIT_MV;
        base_mv   = ext ? AVS_BASE_MV : PPS_BASE_MV;
        if (!ent[14])
        begin
            ent_kind = pdps_pkg::KIND_FIXED;
        end
        else if (ext)
        begin
            ent_kind = pdps_pkg::KIND_AVS;
        end
        else
        begin
            ent_kind = pdps_pkg::KIND_PPS;
        end
        max_prod  = ent[7:0] * unit_mv;
        min_prod  = ent[9:8] * unit_mv;
        max_mv    = max_prod[15:0];
        min_mv    = min_prod[15:0] + base_mv;
        want_kind = (cmd_reg == pdps_pkg::CMD_AVS) ? pdps_pkg::KIND_AVS
                                                   : pdps_pkg::KIND_PPS;
        range_hit = ent_valid && (ent_kind == want_kind)
                    && (mv_reg >= min_mv) && (mv_reg <= max_mv);
        fixed_ok  = ent_valid && (ent_kind == pdps_pkg::KIND_FIXED)
                    && ({3'd0, pdps_pkg::amp_ma(ent_code)} >= ma_reg);
        diff      = (max_mv >= mv_reg) ? max_mv - mv_reg : mv_reg - max_mv;
    end

    // search results
    logic          found_reg, best_hit_reg;
    logic [IW-1:0] hit_idx_reg, best_idx_reg;
    logic [3:0]    hit_code_reg, best_code_reg;
    logic [15:0]   near_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_hit_reg <= 1'b0;
            near_gap_reg <= 16'hFFFF;
        end
        else if (ctl.capture)
        begin
            found_reg    <= 1'b0;
            best_hit_reg <= 1'b0;
            near_gap_reg <= 16'hFFFF;
        end
        else if (ctl.sweep)
        begin
            if (range_hit && !found_reg)
            begin
                found_reg <= 1'b1;
            end
            if (fixed_ok && (diff < near_gap_reg))
            begin
                best_hit_reg <= 1'b1;
                near_gap_reg <= diff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sweep && range_hit && !found_reg)
        begin
            hit_idx_reg  <= ctl.idx;
            hit_code_reg <= ent_code;
        end
        if (ctl.sweep && fixed_ok && (diff < near_gap_reg))
        begin
            best_idx_reg  <= ctl.idx;
            best_code_reg <= ent_code;
        end
    end

    // result formation
    logic [15:0] cap_ma, hit_ma;
    logic [3:0]  idx_next;
    logic [15:0] word_next;
    logic        avs_next;

    always_comb
    begin
        hit_ma    = {3'd0, pdps_pkg::amp_ma(hit_code_reg)};
        cap_ma    = (ma_reg > hit_ma) ? hit_ma : ma_reg;
        idx_next  = 4'd0;
        word_next = 16'd0;
        avs_next  = 1'b0;
        if (cmd_reg != pdps_pkg::CMD_LOAD)
        begin
            if (found_reg)
            begin
                idx_next  = 4'(hit_idx_reg) + 4'd1;
                word_next = {idx_next, pdps_pkg::encode_amps(cap_ma), q_reg[7:0]};
                avs_next  = (cmd_reg == pdps_pkg::CMD_AVS);
            end
            else if ((cmd_reg == pdps_pkg::CMD_REQ) && best_hit_reg)
            begin
                idx_next  = 4'(best_idx_reg) + 4'd1;
                word_next = {idx_next, best_code_reg, 8'd0};
            end
        end
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            chosen_index      <= idx_next;
            request_word      <= word_next;
            is_adjustable_avs <= avs_next;
            valid_count       <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_full = out_valid_reg;

endmodule

FILE: rtl/pd_power_profile_selector.sv
// Load request: the table is written at the accept, then S_FINISH registers the result.
// Other requests: S_SWEEP reads the table one entry per cycle through
// its single read port, then S_FINISH registers the result.
// A new request is taken only once the previous result has been registered.
// A result still held by out_stall when the next is ready delays it by that stall.
// Reset: asynchronous, clears every profile (all invalid), the count and the output valid flag.
module pd_power_profile_selector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [3:0]  slot,
    input  logic [15:0] profile_word,
    input  logic [15:0] target_mv,
    input  logic [15:0] current_ma,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  chosen_index,
    output logic [15:0] request_word,
    output logic        is_adjustable_avs,
    output logic [3:0]  valid_count
);

    pdps_pkg::ctl_t ctl;
    pdps_pkg::sts_t sts;

    pdps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    pdps_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .sts               (sts),
        .command           (command),
        .slot              (slot),
        .profile_word      (profile_word),
        .target_mv         (target_mv),
        .current_ma        (current_ma),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .chosen_index      (chosen_index),
        .request_word      (request_word),
        .is_adjustable_avs (is_adjustable_avs),
        .valid_count       (valid_count)
    );

    a_avs_has_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_adjustable_avs) |-> (chosen_index != 4'd0))
        else $error("avs flag without chosen profile");

    a_none_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (chosen_index == 4'd0)) |-> (request_word == 16'd0))
        else $error("request word set with no profile chosen");

    a_word_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (chosen_index != 4'd0)) |-> (request_word[15:12] == chosen_index))
        else $error("request word index differs from chosen index");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_count <= 4'(pdps_pkg::NUM_PROFILES)))
        else $error("valid count exceeds table depth");

endmodule
